// ===== design/ssi_pkg.sv =====
package ssi_pkg;

    localparam int CoordW = 32;
    localparam int RadiusW = 31;
    localparam int LimitW = 32;
    localparam int CfgDataW = 32;

    typedef enum logic
    {
        REG_RADIUS = 1'b0,
        REG_LIMIT  = 1'b1
    } cfg_idx_t;

    typedef struct packed
    {
        logic [CoordW-1:0] start_x;
        logic [CoordW-1:0] start_y;
        logic [CoordW-1:0] start_z;
        logic [CoordW-1:0] end_x;
        logic [CoordW-1:0] end_y;
        logic [CoordW-1:0] end_z;
    } seg_t;

    typedef struct packed
    {
        logic              hit;
        logic [CoordW-1:0] first_x;
        logic [CoordW-1:0] first_y;
        logic [CoordW-1:0] first_z;
        logic [CoordW-1:0] second_x;
        logic [CoordW-1:0] second_y;
        logic [CoordW-1:0] second_z;
    } isect_t;

endpackage

// ===== design/segment_sphere_intersect_core.sv =====
// Channel   | Ports                            | Handshake
// ----------+----------------------------------+------------------------------------
// command   | start, busy, segment             | word taken when start and not busy
// result    | done, result                     | word valid for the single done cycle
// config    | cfg_we, cfg_index, cfg_data      | register written when cfg_we is high
//
// A word may be issued in every cycle; busy stays low.
// Each result passes six arithmetic stages, 68 square root stages (one root bit each),
// three stages to form the dividends and 32 divider stages (one quotient bit each),
// then the output register.
// Reset clears all valid bits and loads the register defaults.
// The pipeline never stalls; the receiver must always take the result, as the block cannot hold it.
module segment_sphere_intersect_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  ssi_pkg::seg_t                segment,
    output logic                         done,
    output ssi_pkg::isect_t              result,
    input  logic                         cfg_we,
    input  ssi_pkg::cfg_idx_t            cfg_index,
    input  logic [ssi_pkg::CfgDataW-1:0] cfg_data
);
    import ssi_pkg::*;

    localparam int DpW = 34;
    localparam int AW = 66;
    localparam int BW = 67;
    localparam int RemW = 136;
    localparam int SqW = 68;
    localparam int NumW = 67;
    localparam int D2W = 68;
    localparam int TW = 101;
    localparam int QW = 32;
    localparam int Lat = 6 + SqW + 3 + QW + 1;

    typedef struct packed
    {
        logic [2:0][CoordW-1:0] p1;
        logic [2:0][DpW-1:0]    dp;
    } geo_t;

    typedef struct packed
    {
        logic            nohit;
        logic [RemW-1:0] rem;
        logic [SqW-1:0]  root;
        geo_t            geo;
        logic [AW-1:0]   a;
        logic [BW-1:0]   b;
    } sq_t;

    typedef struct packed
    {
        logic                      hit;
        logic [D2W-1:0]            d2;
        logic [1:0][2:0][TW-1:0]   rem;
        logic [1:0][2:0][QW-1:0]   q;
        logic [2:0][CoordW-1:0]    p1;
        logic [2:0]                dneg;
    } dv_t;

    logic [RadiusW-1:0] radius_reg;
    logic [LimitW-1:0]  limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RadiusW'(65536);
            limit_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data[RadiusW-1:0];
                REG_LIMIT:  limit_reg  <= cfg_data[LimitW-1:0];
                default:    limit_reg  <= limit_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // Valid bits of the arithmetic front stages.
    logic [5:1] v_reg;
    logic       vn_reg;
    logic       vm_reg;
    logic       sv_reg [0:SqW];
    logic       dvv_reg [0:QW];
    logic       done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            sv_reg[0] <= 1'b0;
            vn_reg    <= 1'b0;
            vm_reg    <= 1'b0;
            dvv_reg[0] <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v_reg     <= {v_reg[4:1], start & ~busy};
            sv_reg[0] <= v_reg[5];
            vn_reg    <= sv_reg[SqW];
            vm_reg    <= vn_reg;
            dvv_reg[0] <= vm_reg;
            done_reg  <= dvv_reg[QW];
        end
    end

    // Stage 1: direction vector.
    geo_t g1_next, g1_reg;
    logic [2:0][CoordW-1:0] s_in, e_in;

    assign s_in = {segment.start_z, segment.start_y, segment.start_x};
    assign e_in = {segment.end_z, segment.end_y, segment.end_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            g1_next.p1[i] = s_in[i];
            g1_next.dp[i] = DpW'($signed(e_in[i])) - DpW'($signed(s_in[i]));
        end
    end

    // Stage 2: per axis products and the squared radius.
    geo_t                   g2_reg;
    logic [2:0][AW-1:0]     dd_next, dd_reg;
    logic [2:0][AW-1:0]     dh_next, dh_reg;
    logic [2:0][63:0]       pp_next, pp_reg;
    logic [61:0]            rr2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd_next[i] = $signed(g1_reg.dp[i]) * $signed(g1_reg.dp[i]);
            dh_next[i] = $signed(g1_reg.dp[i]) * $signed(g1_reg.p1[i]);
            pp_next[i] = $signed(g1_reg.p1[i]) * $signed(g1_reg.p1[i]);
        end
    end

    // Stage 3: quadratic coefficients.
    geo_t               g3_reg;
    logic [AW-1:0]      a3_next, a3_reg;
    logic [BW-1:0]      b3_next, b3_reg;
    logic               cneg3_next, cneg3_reg;
    logic [AW-1:0]      babs3_next, babs3_reg;
    logic [63:0]        cabs3_next, cabs3_reg;
    logic signed [AW-1:0] h3, c3;
    logic [63:0]        pps3;

    always_comb
    begin
        a3_next = dd_reg[0] + dd_reg[1] + dd_reg[2];
        h3 = $signed(dh_reg[0]) + $signed(dh_reg[1]) + $signed(dh_reg[2]);
        b3_next = {h3, 1'b0};
        pps3 = pp_reg[0] + pp_reg[1] + pp_reg[2];
        c3 = $signed(AW'(pps3)) - $signed(AW'(rr2_reg));
        cneg3_next = c3[AW-1];
        cabs3_next = cneg3_next ? 64'(-c3) : 64'(c3);
        babs3_next = b3_next[BW-1] ? AW'(-$signed(b3_next)) : b3_next[AW-1:0];
    end

    // Stage 4: partial products of b*b and a*|c|.
    geo_t            g4_reg;
    logic [AW-1:0]   a4_reg;
    logic [BW-1:0]   b4_reg;
    logic            cneg4_reg, deg4_reg;
    logic [65:0]     bll_reg, blh_reg, bhh_reg;
    logic [64:0]     all_reg, alh_reg, ahl_reg, ahh_reg;

    // Stage 5: summed products.
    geo_t            g5_reg;
    logic [AW-1:0]   a5_reg;
    logic [BW-1:0]   b5_reg;
    logic            cneg5_reg, deg5_reg;
    logic [RemW-1:0] bb5_next, bb5_reg, ac5_next, ac5_reg;

    always_comb
    begin
        bb5_next = (RemW'(bhh_reg) << 66) + (RemW'(blh_reg) << 34) + RemW'(bll_reg);
        ac5_next = (RemW'(ahh_reg) << 65) + (RemW'(ahl_reg) << 33)
                 + (RemW'(alh_reg) << 32) + RemW'(all_reg);
    end

    // Stage 6: discriminant.
    sq_t              sq_reg [0:SqW];
    sq_t              sq0_next;
    logic [RemW:0]    ac4_6, disc6;

    always_comb
    begin
        ac4_6 = {ac5_reg[RemW-2:0], 2'b00};
        disc6 = cneg5_reg ? ({1'b0, bb5_reg} + ac4_6) : ({1'b0, bb5_reg} - ac4_6);
        sq0_next.nohit = deg5_reg | disc6[RemW];
        sq0_next.rem   = disc6[RemW-1:0];
        sq0_next.root  = '0;
        sq0_next.geo   = g5_reg;
        sq0_next.a     = a5_reg;
        sq0_next.b     = b5_reg;
    end

    always_ff @(posedge clk)
    begin
        g1_reg  <= g1_next;
        g2_reg  <= g1_reg;
        dd_reg  <= dd_next;
        dh_reg  <= dh_next;
        pp_reg  <= pp_next;
        rr2_reg <= 62'(radius_reg) * 62'(radius_reg);

        g3_reg    <= g2_reg;
        a3_reg    <= a3_next;
        b3_reg    <= b3_next;
        cneg3_reg <= cneg3_next;
        babs3_reg <= babs3_next;
        cabs3_reg <= cabs3_next;

        g4_reg    <= g3_reg;
        a4_reg    <= a3_reg;
        b4_reg    <= b3_reg;
        cneg4_reg <= cneg3_reg;
        deg4_reg  <= a3_reg <= AW'(limit_reg);
        bll_reg   <= 66'(babs3_reg[32:0]) * 66'(babs3_reg[32:0]);
        blh_reg   <= 66'(babs3_reg[32:0]) * 66'(babs3_reg[65:33]);
        bhh_reg   <= 66'(babs3_reg[65:33]) * 66'(babs3_reg[65:33]);
        all_reg   <= 65'(a3_reg[32:0]) * 65'(cabs3_reg[31:0]);
        alh_reg   <= 65'(a3_reg[32:0]) * 65'(cabs3_reg[63:32]);
        ahl_reg   <= 65'(a3_reg[65:33]) * 65'(cabs3_reg[31:0]);
        ahh_reg   <= 65'(a3_reg[65:33]) * 65'(cabs3_reg[63:32]);

        g5_reg    <= g4_reg;
        a5_reg    <= a4_reg;
        b5_reg    <= b4_reg;
        cneg5_reg <= cneg4_reg;
        deg5_reg  <= deg4_reg;
        bb5_reg   <= bb5_next;
        ac5_reg   <= ac5_next;

        sq_reg[0] <= sq0_next;
    end

    // Square root, one root bit per stage, most significant first.
    for (genvar j = 0; j < SqW; j++)
    begin : g_sqrt
        localparam int K = SqW - 1 - j;
        logic [RemW-1:0] trial;
        sq_t             sq_next;

        always_comb
        begin
            trial = (RemW'(sq_reg[j].root) << (K + 1)) | (RemW'(1) << (2 * K));
            sq_next = sq_reg[j];
            if (sq_reg[j].rem >= trial)
            begin
                sq_next.rem  = sq_reg[j].rem - trial;
                sq_next.root = sq_reg[j].root | (SqW'(1) << K);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[j+1] <= 1'b0;
            end
            else
            begin
                sv_reg[j+1] <= sv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[j+1] <= sq_next;
        end
    end

    // Root numerators and the hit test.
    logic                   hitn_next, hitn_reg;
    logic [1:0][NumW-1:0]   num_next, num_reg;
    logic [NumW-1:0]        den_next, den_reg, denm_reg;
    logic [D2W-1:0]         d2_next, d2n_reg, d2m_reg;
    logic [2:0][QW-1:0]     m_next, m_reg;
    logic [2:0]             dneg_next, dnegn_reg, dnegm_reg;
    logic [2:0][CoordW-1:0] p1n_reg, p1m_reg;
    logic                   hitm_reg;
    logic signed [69:0]     nbv, n1v, n2v;

    always_comb
    begin
        nbv = -70'($signed(sq_reg[SqW].b));
        n1v = nbv + $signed(70'(sq_reg[SqW].root));
        n2v = nbv - $signed(70'(sq_reg[SqW].root));
        den_next = {sq_reg[SqW].a, 1'b0};
        d2_next = {sq_reg[SqW].a, 2'b00};
        hitn_next = ~sq_reg[SqW].nohit & ~n2v[69] & (n1v <= $signed(70'(den_next)));
        num_next[0] = n1v[NumW-1:0];
        num_next[1] = n2v[NumW-1:0];
        for (int i = 0; i < 3; i++)
        begin
            dneg_next[i] = sq_reg[SqW].geo.dp[i][DpW-1];
            m_next[i] = dneg_next[i] ? QW'(-$signed(sq_reg[SqW].geo.dp[i]))
                                     : sq_reg[SqW].geo.dp[i][QW-1:0];
        end
    end

    logic [1:0][2:0][65:0] plo_next, plo_reg;
    logic [1:0][2:0][64:0] phi_next, phi_reg;

    always_comb
    begin
        for (int r = 0; r < 2; r++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                plo_next[r][i] = 66'(m_reg[i]) * 66'(num_reg[r][33:0]);
                phi_next[r][i] = 65'(m_reg[i]) * 65'(num_reg[r][NumW-1:34]);
            end
        end
    end

    // Dividend 2*|dp|*num + den over divisor 2*den gives the rounded offset.
    dv_t dv_reg [0:QW];
    dv_t dv0_next;

    always_comb
    begin
        dv0_next.hit  = hitm_reg;
        dv0_next.d2   = d2m_reg;
        dv0_next.q    = '0;
        dv0_next.p1   = p1m_reg;
        dv0_next.dneg = dnegm_reg;
        for (int r = 0; r < 2; r++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv0_next.rem[r][i] = (((TW'(phi_reg[r][i]) << 34) + TW'(plo_reg[r][i])) << 1)
                                   + TW'(denm_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hitn_reg  <= hitn_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        d2n_reg   <= d2_next;
        m_reg     <= m_next;
        dnegn_reg <= dneg_next;
        p1n_reg   <= sq_reg[SqW].geo.p1;

        hitm_reg  <= hitn_reg;
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        denm_reg  <= den_reg;
        d2m_reg   <= d2n_reg;
        dnegm_reg <= dnegn_reg;
        p1m_reg   <= p1n_reg;

        dv_reg[0] <= dv0_next;
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        localparam int K = QW - 1 - j;
        logic [TW-1:0] sub;
        dv_t           dv_next;

        always_comb
        begin
            sub = TW'(dv_reg[j].d2) << K;
            dv_next = dv_reg[j];
            for (int r = 0; r < 2; r++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (dv_reg[j].rem[r][i] >= sub)
                    begin
                        dv_next.rem[r][i] = dv_reg[j].rem[r][i] - sub;
                        dv_next.q[r][i] = dv_reg[j].q[r][i] | (QW'(1) << K);
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dvv_reg[j+1] <= 1'b0;
            end
            else
            begin
                dvv_reg[j+1] <= dvv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[j+1] <= dv_next;
        end
    end

    // Output word.
    isect_t                 result_next, result_reg;
    logic [1:0][2:0][CoordW-1:0] pt;

    always_comb
    begin
        for (int r = 0; r < 2; r++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pt[r][i] = dv_reg[QW].dneg[i] ? dv_reg[QW].p1[i] - dv_reg[QW].q[r][i]
                                              : dv_reg[QW].p1[i] + dv_reg[QW].q[r][i];
            end
        end
        result_next = '0;
        if (dv_reg[QW].hit)
        begin
            result_next.hit      = 1'b1;
            result_next.first_x  = pt[0][0];
            result_next.first_y  = pt[0][1];
            result_next.first_z  = pt[0][2];
            result_next.second_x = pt[1][0];
            result_next.second_y = pt[1][1];
            result_next.second_z = pt[1][2];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done = done_reg;
    assign result = result_reg;

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##Lat done)
        else $error("accepted word produced no result at the pipeline latency");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, Lat))
        else $error("result strobe without a matching accepted word");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.first_x == '0 && result.first_y == '0
            && result.first_z == '0 && result.second_x == '0 && result.second_y == '0
            && result.second_z == '0))
        else $error("miss result carries non-zero points");

endmodule
